>>> hw/rtl/tcvr_pkg.sv
package tcvr_pkg;

  localparam int unsigned NumServices = 8;
  localparam int unsigned SlotWidth = 8;
  localparam int unsigned CntWidth = 32;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [16:0] PosMax = 17'h1FFFF;
  localparam logic [16:0] PosIdentHi = 17'd0;
  localparam logic [16:0] PosIdentLo = 17'd1;
  localparam logic [16:0] PosLenHi = 17'd4;
  localparam logic [16:0] PosLenLo = 17'd5;
  localparam logic [16:0] PosType = 17'd7;
  localparam logic [16:0] PosSubtype = 17'd8;
  localparam int unsigned TcTypeBit = 12;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARAM = 2'd1,
    ST_CRC   = 2'd2,
    ST_NOSVC = 2'd3
  } tc_status_t;

  typedef struct packed {
    logic [16:0] pos;
    logic [15:0] ident;
    logic [15:0] len;
    logic [15:0] rx_crc;
    logic [15:0] crc;
    logic [7:0]  type_byte;
    logic [7:0]  subtype;
  } frame_info_t;

  typedef struct packed {
    logic [CntWidth-1:0] rejected_count;
    logic [CntWidth-1:0] accepted_count;
    logic [15:0]         app_data_length;
    logic [7:0]          service_subtype;
    logic [2:0]          service_slot;
    tc_status_t          status;
  } tc_result_t;

endpackage

>>> hw/rtl/tcvr_frame.sv
module tcvr_frame
  import tcvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  output frame_info_t info
);

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [17:0] crc_end;
  logic [17:0] pos_ext;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  always_comb begin
    ident_nxt = ident_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    sub_nxt   = sub_r;
    unique case (pos_r)
      PosIdentHi: ident_nxt = {frame_byte, ident_r[7:0]};
      PosIdentLo: ident_nxt = {ident_r[15:8], frame_byte};
      PosLenHi:   len_nxt   = {frame_byte, len_r[7:0]};
      PosLenLo:   len_nxt   = {len_r[15:8], frame_byte};
      PosType:    type_nxt  = frame_byte;
      PosSubtype: sub_nxt   = frame_byte;
      default: begin
      end
    endcase

    // The CRC covers the declared packet less its last two bytes, which
    // carry the received CRC big-endian.
    pos_ext    = {1'b0, pos_r};
    crc_end    = {2'b00, len_nxt} + 18'd5;
    crc_nxt    = crc_r;
    rx_crc_nxt = rx_crc_r;
    if (pos_ext < crc_end) begin
      crc_nxt = crc_byte(crc_r, frame_byte);
    end else if (pos_ext == crc_end) begin
      rx_crc_nxt = {frame_byte, rx_crc_r[7:0]};
    end else if (pos_ext == crc_end + 18'd1) begin
      rx_crc_nxt = {rx_crc_r[15:8], frame_byte};
    end

    pos_nxt = (pos_r < PosMax) ? pos_r + 17'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_last)) begin
      pos_r    <= '0;
      ident_r  <= '0;
      len_r    <= '0;
      rx_crc_r <= '0;
      crc_r    <= CrcInit;
      type_r   <= '0;
      sub_r    <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      ident_r  <= ident_nxt;
      len_r    <= len_nxt;
      rx_crc_r <= rx_crc_nxt;
      crc_r    <= crc_nxt;
      type_r   <= type_nxt;
      sub_r    <= sub_nxt;
    end
  end

  assign info.pos       = pos_r;
  assign info.ident     = ident_nxt;
  assign info.len       = len_nxt;
  assign info.rx_crc    = rx_crc_nxt;
  assign info.crc       = crc_nxt;
  assign info.type_byte = type_nxt;
  assign info.subtype   = sub_nxt;

endmodule

>>> hw/rtl/tcvr_judge.sv
module tcvr_judge
  import tcvr_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic                             out_ready,
  input  logic [NumServices*SlotWidth-1:0] slots,
  input  frame_info_t                      info,
  output logic                             out_valid,
  output tc_result_t                       result
);

  logic                out_vld_r;
  tc_result_t          res_r;
  logic [CntWidth-1:0] acc_r, acc_nxt;
  logic [CntWidth-1:0] rej_r, rej_nxt;
  tc_status_t          status;
  logic [2:0]          slot;
  logic [7:0]          sub;
  logic [15:0]         app_len;
  logic                found;
  logic [2:0]          found_idx;
  logic [17:0]         pos_ext;
  logic [17:0]         pkt_end;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < NumServices; i++) begin
      if (!found && info.type_byte != 8'd0 &&
          slots[i*SlotWidth +: SlotWidth] == info.type_byte) begin
        found     = 1'b1;
        found_idx = 3'(i);
      end
    end

    pos_ext = {1'b0, info.pos};
    pkt_end = {2'b00, info.len} + 18'd6;
    slot    = '0;
    sub     = '0;
    app_len = '0;
    priority if (info.pos < 17'd7) begin
      status = ST_PARAM;
    end else if (pkt_end > pos_ext) begin
      status = ST_PARAM;
    end else if (info.rx_crc != info.crc) begin
      status = ST_CRC;
    end else if (!info.ident[TcTypeBit]) begin
      status = ST_PARAM;
    end else if (info.len < 16'd8) begin
      status = ST_PARAM;
    end else begin
      sub     = info.subtype;
      app_len = (info.len > 16'd10) ? info.len - 16'd10 : 16'd0;
      if (found) begin
        status = ST_OK;
        slot   = found_idx;
      end else begin
        status = ST_NOSVC;
      end
    end

    acc_nxt = acc_r;
    rej_nxt = rej_r;
    if (status == ST_OK) begin
      if (acc_r != '1) begin
        acc_nxt = acc_r + CntWidth'(1);
      end
    end else if (rej_r != '1) begin
      rej_nxt = rej_r + CntWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      acc_r     <= '0;
      rej_r     <= '0;
    end else if (load) begin
      out_vld_r <= 1'b1;
      acc_r     <= acc_nxt;
      rej_r     <= rej_nxt;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.status          <= status;
      res_r.service_slot    <= slot;
      res_r.service_subtype <= sub;
      res_r.app_data_length <= app_len;
      res_r.accepted_count  <= acc_nxt;
      res_r.rejected_count  <= rej_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign result    = res_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_vld_r || out_ready))
    else $error("result register overwritten while its result was stalled");

  a_counts_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ((acc_r != $past(acc_r)) || (rej_r != $past(rej_r)) ||
              ($past(acc_r) == '1) || ($past(rej_r) == '1)))
    else $error("a result left both counters unchanged");

endmodule

>>> hw/rtl/telecommand_validate_and_route.sv
// Telecommand validator and router.
// Input channel in_*: one frame byte per request in in_tdata, in_tlast on the
// final byte of a frame. Result channel out_*: one request per frame, given
// after the byte flagged last, carrying status, slot, subtype, application
// data length and the saturating accepted and rejected counters.
// Configuration: cfg_wr_en with cfg_wr_data writes the eight packed service
// types; write it only while no frame is in flight.
// Throughput is one byte per cycle, except that a last byte waits for a
// free result register. A byte is held in the input register, then the CRC
// step, header capture and the frame checks run in one pass into the result
// register, which raises out_tvalid when it takes the last byte's result.
// Reset clears the frame state, the counters and the service slots.
// When the receiver stalls, bytes that are not last keep flowing; a last
// byte waits in the input register until the result register is free, and
// then the input stalls behind it.
module telecommand_validate_and_route
  import tcvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // frame_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [1:0] status, [4:2] service_slot,
                                  // [12:5] service_subtype,
                                  // [28:13] app_data_length,
                                  // [60:29] accepted_count,
                                  // [92:61] rejected_count
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [63:0] slots_r;
  logic        out_free;
  logic        step;
  logic        load;
  frame_info_t info;
  tc_result_t  result;

  assign out_free  = !out_tvalid || out_tready;
  assign step      = in_vld_r && (!in_last_r || out_free);
  assign load      = step && in_last_r;
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
    end else if (cfg_wr_en) begin
      slots_r <= cfg_wr_data;
    end
  end

  tcvr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .frame_byte (in_byte_r),
    .frame_last (in_last_r),
    .info       (info)
  );

  tcvr_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .out_ready (out_tready),
    .slots     (slots_r),
    .info      (info),
    .out_valid (out_tvalid),
    .result    (result)
  );

  assign out_tdata = {3'b000, result};

  a_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !in_last_r) |-> step)
    else $error("a byte that is not last was held back");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_vld_r && in_last_r))
    else $error("a result appeared without a last byte");

  a_slot_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != ST_OK) |-> (out_tdata[4:2] == 3'd0))
    else $error("slot reported on a rejected request");

endmodule
